FILE: src/jsu_pkg.sv
`default_nettype none

package jsu_pkg;

  // decoder phases
  localparam logic [3:0] PH_IDLE = 4'd0;
  localparam logic [3:0] PH_BODY = 4'd1;
  localparam logic [3:0] PH_ESC  = 4'd2;
  localparam logic [3:0] PH_HEX  = 4'd3;
  localparam logic [3:0] PH_LBS  = 4'd4;
  localparam logic [3:0] PH_LU   = 4'd5;
  localparam logic [3:0] PH_LD   = 4'd6;
  localparam logic [3:0] PH_LX   = 4'd7;
  localparam logic [3:0] PH_LHEX = 4'd8;
  localparam logic [3:0] PH_CONT = 4'd9;

  // result kinds
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ERR   = 2'd2;
  localparam logic [1:0] KIND_NOSTR = 2'd3;

  // error codes
  localparam logic [2:0] ERR_NONE = 3'd0;
  localparam logic [2:0] ERR_END  = 3'd1;
  localparam logic [2:0] ERR_ESC  = 3'd2;
  localparam logic [2:0] ERR_SURR = 3'd3;
  localparam logic [2:0] ERR_SEQ  = 3'd4;
  localparam logic [2:0] ERR_CHAR = 3'd5;

  // most results one input byte can cause
  localparam int unsigned MaxRes = 4;

  typedef struct packed {
    logic [3:0]  phase;
    logic [20:0] code_accum;
    logic [1:0]  digit_count;
    logic [7:0]  utf8_lead;
    logic [1:0]  utf8_remaining;
    logic [15:0] byte_count;
  } state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  out_value;
    logic [2:0]  error_code;
    logic [15:0] str_length;
  } result_t;

  typedef struct packed {
    logic [2:0]                cnt;
    result_t [MaxRes-1:0]      ent;
  } burst_t;

endpackage

`default_nettype wire

FILE: src/json_string_unescape_utf8.sv
`default_nettype none

// channel   dir  handshake             payload
// s_axis    in   tvalid/tready         tdata: in_byte, tuser: at_end
// m_axis    out  tvalid/tready/tlast   tdata: out_value, error_code, str_length
//                                      tuser: kind
// cfg       in   cfg_valid/cfg_ready   cfg_data: null_terminate
//
// an input byte is registered, then decoded combinationally into a burst of up
// to four results held in the result register. one byte per cycle while each
// byte yields at most one result and m_axis does not stall; a byte with several
// results holds the decode stage until the single result port has handed out
// its last. stalls on m_axis back up through the burst register into the input
// register. reset returns to idle, null mode on.
module json_string_unescape_utf8 (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] in_byte
  input  wire logic [0:0]  s_axis_tuser_i,   // [0] at_end
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [31:0]      m_axis_tdata_o,   // [7:0] out_value, [10:8] error_code,
                                             // [26:11] str_length, rest zero
  output logic [1:0]       m_axis_tuser_o,   // [1:0] kind
  output logic             m_axis_tlast_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_data_i
);

  logic             in_valid_q;
  logic [7:0]       in_byte_q;
  logic             in_end_q;
  logic             null_q;
  jsu_pkg::state_t  st_q;
  jsu_pkg::state_t  st_d;
  jsu_pkg::burst_t  burst;
  jsu_pkg::result_t res;
  logic             buf_free;
  logic             step_fire;

  // decode fires when the result register can take the burst
  assign step_fire       = in_valid_q && buf_free;
  assign s_axis_tready_o = !in_valid_q || step_fire;
  assign cfg_ready_o     = 1'b1;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_byte_q <= s_axis_tdata_i;
      in_end_q  <= s_axis_tuser_i[0];
    end
  end

  // decoder state and configuration, all-zero state is idle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= '0;
      null_q     <= 1'b1;
    end else begin
      if (step_fire) st_q <= st_d;
      if (cfg_valid_i) null_q <= cfg_data_i;
    end
  end

  jsu_step u_step (
    .st_i        (st_q),
    .byte_i      (in_byte_q),
    .end_i       (in_end_q),
    .null_term_i (null_q),
    .st_o        (st_d),
    .burst_o     (burst)
  );

  jsu_outbuf u_outbuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (step_fire && burst.cnt != 3'd0),
    .burst_i (burst),
    .free_o  (buf_free),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .res_o   (res),
    .last_o  (m_axis_tlast_o)
  );

  // output packing
  assign m_axis_tdata_o = {5'd0, res.str_length, res.error_code, res.out_value};
  assign m_axis_tuser_o = res.kind;

endmodule

`default_nettype wire

FILE: src/jsu_step.sv
`default_nettype none

// one decoder step: current state and one document byte give the next state
// and the burst of results that byte causes
module jsu_step (
  input  var jsu_pkg::state_t st_i,
  input  wire logic [7:0]     byte_i,
  input  wire logic           end_i,
  input  wire logic           null_term_i,
  output jsu_pkg::state_t     st_o,
  output jsu_pkg::burst_t     burst_o
);

  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChB      = 8'h62;
  localparam logic [7:0] ChF      = 8'h66;
  localparam logic [7:0] ChN      = 8'h6E;
  localparam logic [7:0] ChR      = 8'h72;
  localparam logic [7:0] ChT      = 8'h74;
  localparam logic [7:0] ChU      = 8'h75;
  localparam logic [7:0] ChUpC    = 8'h43;
  localparam logic [7:0] ChUpD    = 8'h44;
  localparam logic [7:0] ChUpF    = 8'h46;
  localparam logic [7:0] ChLoC    = 8'h63;
  localparam logic [7:0] ChLoD    = 8'h64;
  localparam logic [7:0] ChLoF    = 8'h66;

  typedef struct packed {
    logic [2:0]      n;
    logic [3:0][7:0] b;
  } enc_t;

  // hex digit decode: bit 4 is the valid flag
  function automatic logic [4:0] hex_dec(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    return r;
  endfunction

  // continuation bytes that follow a lead byte
  function automatic logic [1:0] lead_len(input logic [7:0] lead);
    logic [1:0] r;
    if (lead < 8'hE0) r = 2'd1;
    else if (lead < 8'hF0) r = 2'd2;
    else r = 2'd3;
    return r;
  endfunction

  // code point to utf-8 bytes
  function automatic enc_t utf8_enc(input logic [20:0] cp);
    enc_t e;
    e = '0;
    if (cp < 21'h80) begin
      e.n    = 3'd1;
      e.b[0] = cp[7:0];
    end else if (cp < 21'h800) begin
      e.n    = 3'd2;
      e.b[0] = {3'b110, cp[10:6]};
      e.b[1] = {2'b10, cp[5:0]};
    end else if (cp < 21'h10000) begin
      e.n    = 3'd3;
      e.b[0] = {4'b1110, cp[15:12]};
      e.b[1] = {2'b10, cp[11:6]};
      e.b[2] = {2'b10, cp[5:0]};
    end else begin
      e.n    = 3'd4;
      e.b[0] = {5'b11110, cp[20:18]};
      e.b[1] = {2'b10, cp[17:12]};
      e.b[2] = {2'b10, cp[11:6]};
      e.b[3] = {2'b10, cp[5:0]};
    end
    return e;
  endfunction

  jsu_pkg::state_t  st_d;
  jsu_pkg::result_t tail;
  logic             tail_en;
  logic             tail_done;
  logic [2:0]       nbytes;
  logic [3:0][7:0]  bvals;
  logic             clr_bc;
  logic             go_idle;
  logic             do_enc;
  logic [20:0]      enc_cp;
  enc_t             enc;
  logic [4:0]       hx;
  logic [15:0]      acc16;
  logic [1:0]       rem_dec;
  logic             first;
  logic             bad;
  logic [16:0]      bc_sum;
  logic [15:0]      bc_new;
  logic [15:0]      bc_base;

  always_comb begin
    st_d      = st_i;
    tail      = '0;
    tail_en   = 1'b0;
    tail_done = 1'b0;
    nbytes    = '0;
    bvals     = '0;
    clr_bc    = 1'b0;
    go_idle   = 1'b0;
    do_enc    = 1'b0;
    enc_cp    = '0;
    hx        = hex_dec(byte_i);
    acc16     = {st_i.code_accum[11:0], hx[3:0]};
    rem_dec   = st_i.utf8_remaining - 2'd1;
    first     = (st_i.utf8_remaining == lead_len(st_i.utf8_lead));
    bad       = 1'b0;

    // phase dispatch
    if (st_i.phase == jsu_pkg::PH_IDLE) begin
      if (end_i || byte_i != ChQuote) begin
        tail_en   = 1'b1;
        tail.kind = jsu_pkg::KIND_NOSTR;
      end else begin
        st_d                = '0;
        st_d.phase          = jsu_pkg::PH_BODY;
        clr_bc              = 1'b1;
      end
    end else if (end_i) begin
      tail_en         = 1'b1;
      tail.kind       = jsu_pkg::KIND_ERR;
      tail.error_code = jsu_pkg::ERR_END;
      go_idle         = 1'b1;
    end else begin
      unique case (st_i.phase)
        jsu_pkg::PH_BODY: begin
          if (byte_i == ChQuote) begin
            if (null_term_i) nbytes = 3'd1;
            tail_en   = 1'b1;
            tail_done = 1'b1;
            tail.kind = jsu_pkg::KIND_DONE;
            go_idle   = 1'b1;
          end else if (byte_i == ChBslash) begin
            st_d.phase = jsu_pkg::PH_ESC;
          end else if (byte_i < 8'h20) begin
            tail_en         = 1'b1;
            tail.kind       = jsu_pkg::KIND_ERR;
            tail.error_code = jsu_pkg::ERR_CHAR;
            go_idle         = 1'b1;
          end else if (byte_i < 8'h80) begin
            nbytes   = 3'd1;
            bvals[0] = byte_i;
          end else if (byte_i < 8'hC2 || byte_i > 8'hF4) begin
            tail_en         = 1'b1;
            tail.kind       = jsu_pkg::KIND_ERR;
            tail.error_code = jsu_pkg::ERR_SEQ;
            go_idle         = 1'b1;
          end else begin
            nbytes              = 3'd1;
            bvals[0]            = byte_i;
            st_d.utf8_lead      = byte_i;
            st_d.utf8_remaining = lead_len(byte_i);
            st_d.phase          = jsu_pkg::PH_CONT;
          end
        end
        jsu_pkg::PH_CONT: begin
          bad = byte_i < 8'h80 || byte_i > 8'hBF;
          if (first) begin
            if ((st_i.utf8_lead == 8'hE0 && byte_i < 8'hA0) ||
                (st_i.utf8_lead == 8'hED && byte_i > 8'h9F) ||
                (st_i.utf8_lead == 8'hF0 && byte_i < 8'h90) ||
                (st_i.utf8_lead == 8'hF4 && byte_i > 8'h8F)) begin
              bad = 1'b1;
            end
          end
          if (bad) begin
            tail_en         = 1'b1;
            tail.kind       = jsu_pkg::KIND_ERR;
            tail.error_code = jsu_pkg::ERR_SEQ;
            go_idle         = 1'b1;
          end else begin
            nbytes              = 3'd1;
            bvals[0]            = byte_i;
            st_d.utf8_remaining = rem_dec;
            if (rem_dec == 2'd0) st_d.phase = jsu_pkg::PH_BODY;
          end
        end
        jsu_pkg::PH_ESC: begin
          st_d.phase = jsu_pkg::PH_BODY;
          nbytes     = 3'd1;
          unique case (byte_i)
            ChQuote:  bvals[0] = ChQuote;
            ChBslash: bvals[0] = ChBslash;
            ChSlash:  bvals[0] = ChSlash;
            ChB:      bvals[0] = 8'h08;
            ChF:      bvals[0] = 8'h0C;
            ChN:      bvals[0] = 8'h0A;
            ChR:      bvals[0] = 8'h0D;
            ChT:      bvals[0] = 8'h09;
            ChU: begin
              nbytes           = 3'd0;
              st_d.code_accum  = '0;
              st_d.digit_count = '0;
              st_d.phase       = jsu_pkg::PH_HEX;
            end
            default: begin
              nbytes          = 3'd0;
              tail_en         = 1'b1;
              tail.kind       = jsu_pkg::KIND_ERR;
              tail.error_code = jsu_pkg::ERR_ESC;
              go_idle         = 1'b1;
            end
          endcase
        end
        jsu_pkg::PH_HEX: begin
          if (!hx[4]) begin
            tail_en         = 1'b1;
            tail.kind       = jsu_pkg::KIND_ERR;
            tail.error_code = jsu_pkg::ERR_ESC;
            go_idle         = 1'b1;
          end else begin
            st_d.code_accum = {5'd0, acc16};
            if (st_i.digit_count != 2'd3) begin
              st_d.digit_count = st_i.digit_count + 2'd1;
            end else begin
              st_d.digit_count = '0;
              if (acc16 >= 16'hD800 && acc16 < 16'hDC00) begin
                // high surrogate: keep the upper ten bits plus the plane offset
                st_d.code_accum = {11'({1'b0, acc16[9:0]} + 11'h40), 10'd0};
                st_d.phase      = jsu_pkg::PH_LBS;
              end else if (acc16 >= 16'hDC00 && acc16 < 16'hE000) begin
                tail_en         = 1'b1;
                tail.kind       = jsu_pkg::KIND_ERR;
                tail.error_code = jsu_pkg::ERR_SURR;
                go_idle         = 1'b1;
              end else begin
                do_enc = 1'b1;
                enc_cp = {5'd0, acc16};
              end
            end
          end
        end
        jsu_pkg::PH_LBS: begin
          if (byte_i != ChBslash) begin
            tail_en         = 1'b1;
            tail.kind       = jsu_pkg::KIND_ERR;
            tail.error_code = jsu_pkg::ERR_SURR;
            go_idle         = 1'b1;
          end else begin
            st_d.phase = jsu_pkg::PH_LU;
          end
        end
        jsu_pkg::PH_LU: begin
          if (byte_i != ChU) begin
            tail_en         = 1'b1;
            tail.kind       = jsu_pkg::KIND_ERR;
            tail.error_code = jsu_pkg::ERR_SURR;
            go_idle         = 1'b1;
          end else begin
            st_d.phase = jsu_pkg::PH_LD;
          end
        end
        jsu_pkg::PH_LD: begin
          if (byte_i != ChUpD && byte_i != ChLoD) begin
            tail_en         = 1'b1;
            tail.kind       = jsu_pkg::KIND_ERR;
            tail.error_code = jsu_pkg::ERR_SURR;
            go_idle         = 1'b1;
          end else begin
            st_d.phase = jsu_pkg::PH_LX;
          end
        end
        jsu_pkg::PH_LX: begin
          if ((byte_i >= ChUpC && byte_i <= ChUpF) ||
              (byte_i >= ChLoC && byte_i <= ChLoF)) begin
            // c..f maps to 0..3 in both cases
            st_d.code_accum  = st_i.code_accum | {11'd0, byte_i[1:0] + 2'd1, 8'd0};
            st_d.digit_count = '0;
            st_d.phase       = jsu_pkg::PH_LHEX;
          end else begin
            tail_en         = 1'b1;
            tail.kind       = jsu_pkg::KIND_ERR;
            tail.error_code = jsu_pkg::ERR_SURR;
            go_idle         = 1'b1;
          end
        end
        jsu_pkg::PH_LHEX: begin
          if (!hx[4]) begin
            tail_en         = 1'b1;
            tail.kind       = jsu_pkg::KIND_ERR;
            tail.error_code = jsu_pkg::ERR_ESC;
            go_idle         = 1'b1;
          end else if (st_i.digit_count == 2'd0) begin
            st_d.code_accum  = st_i.code_accum | {13'd0, hx[3:0], 4'd0};
            st_d.digit_count = 2'd1;
          end else begin
            st_d.code_accum  = st_i.code_accum | {17'd0, hx[3:0]};
            st_d.digit_count = '0;
            do_enc           = 1'b1;
            enc_cp           = st_i.code_accum | {17'd0, hx[3:0]};
          end
        end
        default: begin
          go_idle = 1'b1;
        end
      endcase
    end

    // code point output, escaped zero is refused in null mode
    enc = utf8_enc(enc_cp);
    if (do_enc) begin
      if (null_term_i && enc_cp == 21'd0) begin
        tail_en         = 1'b1;
        tail.kind       = jsu_pkg::KIND_ERR;
        tail.error_code = jsu_pkg::ERR_CHAR;
        go_idle         = 1'b1;
      end else begin
        nbytes     = enc.n;
        bvals      = enc.b;
        st_d.phase = jsu_pkg::PH_BODY;
      end
    end

    if (go_idle) begin
      st_d.phase          = jsu_pkg::PH_IDLE;
      st_d.code_accum     = '0;
      st_d.digit_count    = '0;
      st_d.utf8_lead      = '0;
      st_d.utf8_remaining = '0;
    end

    // saturating length
    bc_base = clr_bc ? 16'd0 : st_i.byte_count;
    bc_sum  = {1'b0, bc_base} + {14'd0, nbytes};
    bc_new  = bc_sum[16] ? 16'hFFFF : bc_sum[15:0];
    st_d.byte_count = bc_new;
    if (tail_done) tail.str_length = bc_new;
  end

  // burst assembly: decoded bytes first, then the closing item
  always_comb begin
    burst_o     = '0;
    burst_o.cnt = nbytes + {2'd0, tail_en};
    for (int i = 0; i < jsu_pkg::MaxRes; i++) begin
      if (3'(i) < nbytes) begin
        burst_o.ent[i].kind      = jsu_pkg::KIND_BYTE;
        burst_o.ent[i].out_value = bvals[i];
      end else if (tail_en && 3'(i) == nbytes) begin
        burst_o.ent[i] = tail;
      end
    end
  end

  assign st_o = st_d;

endmodule

`default_nettype wire

FILE: src/jsu_outbuf.sv
`default_nettype none

// result register: holds one burst and hands it out one result per cycle while ready_i is high
module jsu_outbuf (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            load_i,
  input  var jsu_pkg::burst_t  burst_i,
  output logic                 free_o,
  output logic                 valid_o,
  input  wire logic            ready_i,
  output jsu_pkg::result_t     res_o,
  output logic                 last_o
);

  jsu_pkg::result_t [jsu_pkg::MaxRes-1:0] ent_q;
  logic [2:0] cnt_q;
  logic [1:0] idx_q;
  logic       take;

  // current result and handshake
  assign valid_o = (cnt_q != 3'd0);
  assign res_o   = ent_q[idx_q];
  assign last_o  = ({1'b0, idx_q} + 3'd1 == cnt_q);
  assign take    = valid_o && ready_i;
  assign free_o  = !valid_o || (take && last_o);

  // burst payload
  always_ff @(posedge clk_i) begin
    if (load_i) ent_q <= burst_i.ent;
  end

  // count and read pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else if (load_i) begin
      cnt_q <= burst_i.cnt;
      idx_q <= '0;
    end else if (take) begin
      if (last_o) begin
        cnt_q <= '0;
        idx_q <= '0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: verif/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam logic [7:0]  CH_QUOTE     = 8'h22;
  localparam logic [7:0]  CH_BSLASH    = 8'h5C;
  localparam int unsigned STUCK_LIMIT  = 1000;
  localparam int unsigned DRAIN_CYCLES = 10;

  typedef struct packed {
    logic       at_end;
    logic [7:0] ch;
  } doc_item_t;

  typedef struct packed {
    logic             is_last;
    jsu_pkg::result_t res;
  } dec_out_t;

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        s_tvalid  = 1'b0;
  logic [7:0]  s_tdata   = 8'h00;
  logic [0:0]  s_tuser   = 1'b0;
  logic        m_tready  = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_data  = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [31:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;
  logic        cfg_ready_o;

  json_string_unescape_utf8 dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data)
  );

  // document bytes waiting to be sent and decoded bytes still owed by the block
  doc_item_t   doc_q[$];
  dec_out_t    owed_q[$];
  dec_out_t    step_q[$];
  doc_item_t   feed_item;
  int unsigned n_queued     = 0;
  int unsigned nfail        = 0;
  int unsigned stuck_cycles = 0;
  int unsigned src_gap      = 0;
  int unsigned sink_gap     = 0;
  logic        quiet        = 1'b0;

  // decoder shadow state
  logic [3:0]  dec_phase   = jsu_pkg::PH_IDLE;
  logic [20:0] cp_acc      = '0;
  logic [1:0]  hex_digits  = '0;
  logic [7:0]  mb_lead     = '0;
  logic [1:0]  mb_left     = '0;
  logic [15:0] out_count   = '0;
  logic        nul_mode    = 1'b1;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- decoder shadow

  function automatic void emit(logic [1:0] k, logic [7:0] v, logic [2:0] e, logic [15:0] len);
    dec_out_t r;
    r.is_last        = 1'b0;
    r.res.kind       = k;
    r.res.out_value  = v;
    r.res.error_code = e;
    r.res.str_length = len;
    step_q.push_back(r);
  endfunction

  function automatic void put_byte(logic [7:0] v);
    emit(jsu_pkg::KIND_BYTE, v, jsu_pkg::ERR_NONE, 16'd0);
    if (out_count != 16'hFFFF) out_count = out_count + 16'd1;
  endfunction

  function automatic void to_idle();
    dec_phase  = jsu_pkg::PH_IDLE;
    cp_acc     = '0;
    hex_digits = '0;
    mb_lead    = '0;
    mb_left    = '0;
  endfunction

  function automatic void abort(logic [2:0] code);
    emit(jsu_pkg::KIND_ERR, 8'h00, code, 16'd0);
    to_idle();
  endfunction

  function automatic int hex_val(logic [7:0] b);
    if (b >= "0" && b <= "9") return int'(b) - int'("0");
    if (b >= "A" && b <= "F") return int'(b) - int'("A") + 10;
    if (b >= "a" && b <= "f") return int'(b) - int'("a") + 10;
    return -1;
  endfunction

  // continuation bytes that follow a utf-8 lead
  function automatic logic [1:0] seq_len(logic [7:0] lead);
    if (lead < 8'hE0) return 2'd1;
    if (lead < 8'hF0) return 2'd2;
    return 2'd3;
  endfunction

  // code point to utf-8, escaped zero is rejected in null mode
  function automatic void emit_cp(logic [20:0] cp);
    if (nul_mode && cp == '0) begin
      abort(jsu_pkg::ERR_CHAR);
    end else begin
      if (cp < 21'h80) begin
        put_byte(cp[7:0]);
      end else if (cp < 21'h800) begin
        put_byte(8'hC0 | 8'(cp >> 6));
        put_byte({2'b10, cp[5:0]});
      end else if (cp < 21'h10000) begin
        put_byte(8'hE0 | 8'(cp >> 12));
        put_byte({2'b10, cp[11:6]});
        put_byte({2'b10, cp[5:0]});
      end else begin
        put_byte({5'b11110, cp[20:18]});
        put_byte({2'b10, cp[17:12]});
        put_byte({2'b10, cp[11:6]});
        put_byte({2'b10, cp[5:0]});
      end
      dec_phase = jsu_pkg::PH_BODY;
    end
  endfunction

  // one input transaction, appends its results to owed_q
  function automatic void decode(logic [7:0] b, logic at_end);
    int         h;
    logic       first;
    logic       bad;
    logic       known;
    logic [7:0] v;
    step_q.delete();
    h = hex_val(b);
    if (dec_phase == jsu_pkg::PH_IDLE) begin
      if (at_end || b != CH_QUOTE) begin
        emit(jsu_pkg::KIND_NOSTR, 8'h00, jsu_pkg::ERR_NONE, 16'd0);
      end else begin
        to_idle();
        out_count = '0;
        dec_phase = jsu_pkg::PH_BODY;
      end
    end else if (at_end) begin
      abort(jsu_pkg::ERR_END);
    end else begin
      case (dec_phase)
        jsu_pkg::PH_BODY: begin
          if (b == CH_QUOTE) begin
            if (nul_mode) put_byte(8'h00);
            emit(jsu_pkg::KIND_DONE, 8'h00, jsu_pkg::ERR_NONE, out_count);
            to_idle();
          end else if (b == CH_BSLASH) begin
            dec_phase = jsu_pkg::PH_ESC;
          end else if (b < 8'h20) begin
            abort(jsu_pkg::ERR_CHAR);
          end else if (b < 8'h80) begin
            put_byte(b);
          end else if (b < 8'hC2 || b > 8'hF4) begin
            abort(jsu_pkg::ERR_SEQ);
          end else begin
            put_byte(b);
            mb_lead   = b;
            mb_left   = seq_len(b);
            dec_phase = jsu_pkg::PH_CONT;
          end
        end
        jsu_pkg::PH_CONT: begin
          first = (mb_left == seq_len(mb_lead));
          bad   = (b < 8'h80 || b > 8'hBF);
          // tighter second-byte ranges for overlongs, surrogates and above 10ffff
          if (first && ((mb_lead == 8'hE0 && b < 8'hA0) || (mb_lead == 8'hED && b > 8'h9F) ||
                        (mb_lead == 8'hF0 && b < 8'h90) || (mb_lead == 8'hF4 && b > 8'h8F)))
            bad = 1'b1;
          if (bad) begin
            abort(jsu_pkg::ERR_SEQ);
          end else begin
            put_byte(b);
            mb_left = mb_left - 2'd1;
            if (mb_left == 2'd0) dec_phase = jsu_pkg::PH_BODY;
          end
        end
        jsu_pkg::PH_ESC: begin
          known = 1'b1;
          case (b)
            CH_QUOTE, CH_BSLASH, "/": v = b;
            "b":     v = 8'h08;
            "f":     v = 8'h0C;
            "n":     v = 8'h0A;
            "r":     v = 8'h0D;
            "t":     v = 8'h09;
            default: begin
              v     = 8'h00;
              known = 1'b0;
            end
          endcase
          if (b == "u") begin
            cp_acc     = '0;
            hex_digits = '0;
            dec_phase  = jsu_pkg::PH_HEX;
          end else if (known) begin
            put_byte(v);
            dec_phase = jsu_pkg::PH_BODY;
          end else begin
            abort(jsu_pkg::ERR_ESC);
          end
        end
        jsu_pkg::PH_HEX: begin
          if (h < 0) begin
            abort(jsu_pkg::ERR_ESC);
          end else begin
            cp_acc = {5'd0, cp_acc[11:0], 4'(h)};
            if (hex_digits < 2'd3) begin
              hex_digits = hex_digits + 2'd1;
            end else begin
              hex_digits = '0;
              if (cp_acc >= 21'hD800 && cp_acc < 21'hDC00) begin
                // high surrogate: keep the upper ten bits plus the 0x10000 offset
                cp_acc    = 21'((int'(cp_acc) - 'hD800 + 'h40) << 10);
                dec_phase = jsu_pkg::PH_LBS;
              end else if (cp_acc >= 21'hDC00 && cp_acc < 21'hE000) begin
                abort(jsu_pkg::ERR_SURR);
              end else begin
                emit_cp(cp_acc);
              end
            end
          end
        end
        jsu_pkg::PH_LBS: begin
          if (b != CH_BSLASH) abort(jsu_pkg::ERR_SURR);
          else dec_phase = jsu_pkg::PH_LU;
        end
        jsu_pkg::PH_LU: begin
          if (b != "u") abort(jsu_pkg::ERR_SURR);
          else dec_phase = jsu_pkg::PH_LD;
        end
        jsu_pkg::PH_LD: begin
          if (b != "D" && b != "d") abort(jsu_pkg::ERR_SURR);
          else dec_phase = jsu_pkg::PH_LX;
        end
        jsu_pkg::PH_LX: begin
          if (b >= "C" && b <= "F") begin
            cp_acc     = cp_acc | (21'(b - 8'h43) << 8);
            hex_digits = '0;
            dec_phase  = jsu_pkg::PH_LHEX;
          end else if (b >= "c" && b <= "f") begin
            cp_acc     = cp_acc | (21'(b - 8'h63) << 8);
            hex_digits = '0;
            dec_phase  = jsu_pkg::PH_LHEX;
          end else begin
            abort(jsu_pkg::ERR_SURR);
          end
        end
        jsu_pkg::PH_LHEX: begin
          if (h < 0) begin
            abort(jsu_pkg::ERR_ESC);
          end else if (hex_digits == 2'd0) begin
            cp_acc     = cp_acc | (21'(h) << 4);
            hex_digits = 2'd1;
          end else begin
            cp_acc     = cp_acc | 21'(h);
            hex_digits = '0;
            emit_cp(cp_acc);
          end
        end
        default: to_idle();
      endcase
    end
    if (step_q.size() != 0) step_q[step_q.size() - 1].is_last = 1'b1;
    foreach (step_q[i]) owed_q.push_back(step_q[i]);
  endfunction

  // ---------------------------------------------------------------- source side

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 8'h00;
      s_tuser  <= 1'b0;
      src_gap  <= 0;
      to_idle();
      out_count = '0;
      nul_mode  = 1'b1;
    end else begin
      if (s_tvalid && s_axis_tready_o) decode(s_tdata, s_tuser[0]);
      if (!s_tvalid || s_axis_tready_o) begin
        if (src_gap != 0 && !quiet) begin
          src_gap  <= src_gap - 1;
          s_tvalid <= 1'b0;
        end else if (doc_q.size() != 0) begin
          feed_item = doc_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= feed_item.ch;
          s_tuser  <= feed_item.at_end;
          src_gap  <= (!quiet && $urandom_range(0, 5) == 0) ? $urandom_range(1, 19) : 0;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- sink side

  function automatic void note_diff(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      nfail++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    end
  endfunction

  task automatic check_result();
    dec_out_t want;
    if (owed_q.size() == 0) begin
      nfail++;
      $display("%0t: unexpected transaction, expected none, actual kind %0h data %0h",
               $time, m_axis_tuser_o, m_axis_tdata_o);
    end else begin
      want = owed_q.pop_front();
      note_diff("kind", 32'(want.res.kind), 32'(m_axis_tuser_o));
      note_diff("out_value", 32'(want.res.out_value), 32'(m_axis_tdata_o[7:0]));
      note_diff("error_code", 32'(want.res.error_code), 32'(m_axis_tdata_o[10:8]));
      note_diff("str_length", 32'(want.res.str_length), 32'(m_axis_tdata_o[26:11]));
      note_diff("tdata pad", 32'd0, 32'(m_axis_tdata_o[31:27]));
      note_diff("tlast", 32'(want.is_last), 32'(m_axis_tlast_o));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
      sink_gap <= 0;
    end else begin
      if (m_axis_tvalid_o && m_tready) check_result();
      if (sink_gap != 0 && !quiet) begin
        sink_gap <= sink_gap - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        sink_gap <= (!quiet && $urandom_range(0, 7) == 0) ? $urandom_range(1, 19) : 0;
      end
    end
  end

  // no transaction anywhere for too long means the block is stuck
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_tvalid && s_axis_tready_o) || (m_axis_tvalid_o && m_tready) ||
          (cfg_valid && cfg_ready_o)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
        $display("FAIL");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic put_item(logic [7:0] c, logic at_end);
    doc_item_t it;
    it.ch     = c;
    it.at_end = at_end;
    doc_q.push_back(it);
    n_queued++;
  endtask

  task automatic put_ch(logic [7:0] c);
    put_item(c, 1'b0);
  endtask

  function automatic logic [7:0] hex_char(int v);
    if (v < 10) return 8'(int'("0") + v);
    return 8'(($urandom_range(0, 1) ? int'("a") : int'("A")) + v - 10);
  endfunction

  function automatic logic [7:0] non_hex();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (hex_val(b) >= 0) b = "g";
    return b;
  endfunction

  function automatic logic is_esc_letter(logic [7:0] b);
    case (b)
      CH_QUOTE, CH_BSLASH, "/", "b", "f", "n", "r", "t", "u": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  task automatic put_u(int v);
    put_ch(CH_BSLASH);
    put_ch("u");
    for (int i = 3; i >= 0; i--) put_ch(hex_char((v >> (4 * i)) & 15));
  endtask

  task automatic put_raw(int cp);
    if (cp < 'h800) begin
      put_ch(8'('hC0 | (cp >> 6)));
      put_ch(8'('h80 | (cp & 'h3F)));
    end else if (cp < 'h10000) begin
      put_ch(8'('hE0 | (cp >> 12)));
      put_ch(8'('h80 | ((cp >> 6) & 'h3F)));
      put_ch(8'('h80 | (cp & 'h3F)));
    end else begin
      put_ch(8'('hF0 | (cp >> 18)));
      put_ch(8'('h80 | ((cp >> 12) & 'h3F)));
      put_ch(8'('h80 | ((cp >> 6) & 'h3F)));
      put_ch(8'('h80 | (cp & 'h3F)));
    end
  endtask

  // one well-formed piece of string body
  task automatic put_fragment();
    string      simple_esc = "\"\\/bfnrt";
    logic [7:0] b;
    int         cp;
    case ($urandom_range(0, 5))
      0: begin
        b = 8'($urandom_range('h20, 'h7F));
        if (b == CH_QUOTE || b == CH_BSLASH) put_ch(CH_BSLASH);
        put_ch(b);
      end
      1: begin
        put_ch(CH_BSLASH);
        put_ch(simple_esc[$urandom_range(0, 7)]);
      end
      2: begin
        case ($urandom_range(0, 3))
          0:       cp = $urandom_range(1, 'h7F);
          1:       cp = $urandom_range('h80, 'h7FF);
          2:       cp = $urandom_range('h800, 'hD7FF);
          default: cp = $urandom_range('hE000, 'hFFFF);
        endcase
        put_u(cp);
      end
      3: begin
        put_u($urandom_range('hD800, 'hDBFF));
        put_u($urandom_range('hDC00, 'hDFFF));
      end
      default: begin
        // raw utf-8, biased toward the leads with narrowed second bytes
        case ($urandom_range(0, 6))
          0:       cp = $urandom_range('h80, 'h7FF);
          1:       cp = $urandom_range('h800, 'hFFF);
          2:       cp = $urandom_range('hD000, 'hD7FF);
          3:       cp = $urandom_range('h1000, 'hFFFF);
          4:       cp = $urandom_range('h10000, 'h3FFFF);
          5:       cp = $urandom_range('h40000, 'hFFFFF);
          default: cp = $urandom_range('h100000, 'h10FFFF);
        endcase
        if (cp >= 'hD800 && cp < 'hE000) cp = cp - 'h1000;
        put_raw(cp);
      end
    endcase
  endtask

  // a broken ending for a string
  task automatic put_fault();
    logic [7:0] b;
    case ($urandom_range(0, 9))
      0: put_item(8'($urandom_range(0, 255)), 1'b1);
      1: put_ch(8'($urandom_range(0, 'h1F)));
      2: put_ch($urandom_range(0, 1) ? 8'($urandom_range('h80, 'hC1))
                                     : 8'($urandom_range('hF5, 'hFF)));
      3: begin
        case ($urandom_range(0, 5))
          0: begin put_ch(8'hE0); put_ch(8'($urandom_range('h80, 'h9F))); end
          1: begin put_ch(8'hED); put_ch(8'($urandom_range('hA0, 'hBF))); end
          2: begin put_ch(8'hF0); put_ch(8'($urandom_range('h80, 'h8F))); end
          3: begin put_ch(8'hF4); put_ch(8'($urandom_range('h90, 'hBF))); end
          4: begin
            put_ch(8'($urandom_range('hC2, 'hDF)));
            put_ch($urandom_range(0, 1) ? 8'($urandom_range(0, 'h7F))
                                        : 8'($urandom_range('hC0, 'hFF)));
          end
          default: begin
            put_ch(8'hF1);
            put_ch(8'h80);
            put_ch(8'($urandom_range('hC0, 'hFF)));
          end
        endcase
      end
      4: begin
        b = 8'($urandom_range(0, 255));
        if (is_esc_letter(b)) b = "x";
        put_ch(CH_BSLASH);
        put_ch(b);
      end
      5: begin
        put_ch(CH_BSLASH);
        put_ch("u");
        repeat ($urandom_range(0, 3)) put_ch(hex_char($urandom_range(0, 15)));
        put_ch(non_hex());
      end
      6: put_u($urandom_range('hDC00, 'hDFFF));
      7: begin
        // high surrogate with the low half broken at some point
        put_u($urandom_range('hD800, 'hDBFF));
        case ($urandom_range(0, 4))
          0: put_ch(8'($urandom_range(0, 255)));
          1: begin put_ch(CH_BSLASH); put_ch(8'($urandom_range(0, 255))); end
          2: begin put_ch(CH_BSLASH); put_ch("u"); put_ch(8'($urandom_range(0, 255))); end
          3: begin
            put_ch(CH_BSLASH);
            put_ch("u");
            put_ch($urandom_range(0, 1) ? "D" : "d");
            put_ch(8'($urandom_range(0, 255)));
          end
          default: begin
            put_ch(CH_BSLASH);
            put_ch("u");
            put_ch("D");
            put_ch(hex_char($urandom_range(12, 15)));
            if ($urandom_range(0, 1)) put_ch(hex_char($urandom_range(0, 15)));
            put_ch(non_hex());
          end
        endcase
      end
      8: put_u(0);
      default: begin
        put_ch(CH_BSLASH);
        if ($urandom_range(0, 1)) begin
          put_ch("u");
          put_ch(hex_char($urandom_range(0, 15)));
        end
        put_item(8'($urandom_range(0, 255)), 1'b1);
      end
    endcase
  endtask

  // one string, sometimes idle noise instead
  task automatic put_doc();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 3))
        put_item(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
    end else begin
      put_ch(CH_QUOTE);
      repeat ($urandom_range(0, 5)) put_fragment();
      if ($urandom_range(0, 9) < 6) put_ch(CH_QUOTE);
      else put_fault();
    end
  endtask

  task automatic put_docs(int unsigned n);
    int unsigned start;
    start = n_queued;
    while (n_queued - start < n) put_doc();
  endtask

  // wait until every byte went in and every result came out, then let the pipe empty
  task automatic settle();
    while (doc_q.size() != 0 || s_tvalid || owed_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_null_mode(logic v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    nul_mode = v;
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: idle rejects, max 4-byte raw char, a tab escape and each error code
    put_ch(8'h00);
    put_item(8'hFF, 1'b1);
    put_ch(CH_QUOTE);
    put_ch(8'hF4); put_ch(8'h8F); put_ch(8'hBF); put_ch(8'hBF);
    put_ch(CH_BSLASH); put_ch("t");
    put_ch(CH_QUOTE);
    put_ch(CH_QUOTE); put_ch(8'h1F);
    put_ch(CH_QUOTE); put_ch(CH_BSLASH); put_ch("q");
    put_ch(CH_QUOTE); put_ch("a"); put_item(CH_QUOTE, 1'b1);
    put_ch(CH_QUOTE); put_ch(8'hFF);
    put_ch(CH_QUOTE); put_ch(CH_BSLASH); put_ch("u");
    put_ch("D"); put_ch("C"); put_ch("0"); put_ch("0");
    settle();

    // random strings under alternating null modes
    set_null_mode(1'b0);
    put_docs(30);
    settle();
    set_null_mode(1'b1);
    put_docs(30);
    settle();
    set_null_mode(1'b0);
    put_docs(20);
    settle();

    // full rate, no idling on either side
    quiet = 1'b1;
    set_null_mode(1'b1);
    put_docs(15);
    settle();

    if (nfail == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

FILE: sim.f
src/jsu_pkg.sv
src/jsu_step.sv
src/jsu_outbuf.sv
src/json_string_unescape_utf8.sv
verif/tb.sv
